// ===== hdl/abkf_pkg.sv =====
// Shared types, register indexes and the fixed micro-program of the angle/bias Kalman filter.
package abkf_pkg;

    localparam int DW       = 32;
    localparam int FB       = 16;
    localparam int QW       = DW + FB;
    localparam int PROG_LEN = 34;
    localparam int PC_W     = 6;

    localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ONE_FX  = DW'(1) << FB;

    localparam logic [16:0] RST_STEP_TIME     = 17'd655;
    localparam logic [30:0] RST_ANGLE_NOISE   = 31'd6554;
    localparam logic [30:0] RST_BIAS_NOISE    = 31'd6554;
    localparam logic [30:0] RST_MEASURE_NOISE = 31'd32768;

    typedef enum logic [2:0] {
        CFG_STEP_TIME     = 3'd0,
        CFG_ANGLE_NOISE   = 3'd1,
        CFG_BIAS_NOISE    = 3'd2,
        CFG_MEASURE_NOISE = 3'd3,
        CFG_OBSERVE_GAIN  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

    typedef enum logic [4:0] {
        R_A, R_B, R_P0, R_P1, R_P2, R_P3, R_ACC, R_GYR, R_ERR, R_TMP,
        R_PD0, R_PD1, R_PCT0, R_PCT1, R_E, R_K0, R_K1, R_T1,
        R_DT, R_QA, R_QG, R_R, R_C, R_ZERO, R_RATE
    } reg_sel_t;

    typedef struct packed {
        op_t      op;
        reg_sel_t dst;
        reg_sel_t src_a;
        reg_sel_t src_b;
    } uop_t;

    typedef struct packed {
        logic          sat;
        logic [DW-1:0] val;
    } sat_val_t;

    // Signed result from sign and magnitude, clamped to the data width.
    function automatic sat_val_t from_mag(input logic neg, input logic [QW-1:0] m);
        sat_val_t r;
        r.sat = 1'b0;
        if (!neg) begin
            if (m > QW'(MAX_VAL)) begin
                r.sat = 1'b1;
                r.val = MAX_VAL;
            end else begin
                r.val = m[DW-1:0];
            end
        end else begin
            if (m > QW'(MIN_VAL)) begin
                r.sat = 1'b1;
                r.val = MIN_VAL;
            end else begin
                r.val = DW'(0) - m[DW-1:0];
            end
        end
        return r;
    endfunction

    // Saturating add or subtract.
    function automatic sat_val_t add_sat(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                         input logic sub);
        sat_val_t         r;
        logic [DW:0]      s;
        s = sub ? ({a[DW-1], a} - {b[DW-1], b}) : ({a[DW-1], a} + {b[DW-1], b});
        r.sat = s[DW] != s[DW-1];
        r.val = r.sat ? (s[DW] ? MIN_VAL : MAX_VAL) : s[DW-1:0];
        return r;
    endfunction

    // One sample: predict, propagate covariance, gains, correct.
    function automatic uop_t prog(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = '{OP_SUB, R_TMP,  R_GYR,  R_B};
            6'd1:  u = '{OP_MUL, R_TMP,  R_TMP,  R_DT};
            6'd2:  u = '{OP_ADD, R_A,    R_A,    R_TMP};
            6'd3:  u = '{OP_SUB, R_ERR,  R_ACC,  R_A};
            6'd4:  u = '{OP_SUB, R_TMP,  R_QA,   R_P1};
            6'd5:  u = '{OP_SUB, R_PD0,  R_TMP,  R_P2};
            6'd6:  u = '{OP_SUB, R_PD1,  R_ZERO, R_P3};
            6'd7:  u = '{OP_MUL, R_TMP,  R_PD0,  R_DT};
            6'd8:  u = '{OP_ADD, R_P0,   R_P0,   R_TMP};
            6'd9:  u = '{OP_MUL, R_TMP,  R_PD1,  R_DT};
            6'd10: u = '{OP_ADD, R_P1,   R_P1,   R_TMP};
            6'd11: u = '{OP_ADD, R_P2,   R_P2,   R_TMP};
            6'd12: u = '{OP_MUL, R_TMP,  R_QG,   R_DT};
            6'd13: u = '{OP_ADD, R_P3,   R_P3,   R_TMP};
            6'd14: u = '{OP_MUL, R_PCT0, R_C,    R_P0};
            6'd15: u = '{OP_MUL, R_PCT1, R_C,    R_P2};
            6'd16: u = '{OP_MUL, R_TMP,  R_C,    R_PCT0};
            6'd17: u = '{OP_ADD, R_E,    R_R,    R_TMP};
            6'd18: u = '{OP_DIV, R_K0,   R_PCT0, R_E};
            6'd19: u = '{OP_DIV, R_K1,   R_PCT1, R_E};
            6'd20: u = '{OP_MUL, R_T1,   R_C,    R_P1};
            6'd21: u = '{OP_MUL, R_TMP,  R_K0,   R_PCT0};
            6'd22: u = '{OP_SUB, R_P0,   R_P0,   R_TMP};
            6'd23: u = '{OP_MUL, R_TMP,  R_K0,   R_T1};
            6'd24: u = '{OP_SUB, R_P1,   R_P1,   R_TMP};
            6'd25: u = '{OP_MUL, R_TMP,  R_K1,   R_PCT0};
            6'd26: u = '{OP_SUB, R_P2,   R_P2,   R_TMP};
            6'd27: u = '{OP_MUL, R_TMP,  R_K1,   R_T1};
            6'd28: u = '{OP_SUB, R_P3,   R_P3,   R_TMP};
            6'd29: u = '{OP_MUL, R_TMP,  R_K0,   R_ERR};
            6'd30: u = '{OP_ADD, R_A,    R_A,    R_TMP};
            6'd31: u = '{OP_MUL, R_TMP,  R_K1,   R_ERR};
            6'd32: u = '{OP_ADD, R_B,    R_B,    R_TMP};
            6'd33: u = '{OP_SUB, R_RATE, R_GYR,  R_B};
            default: u = '{OP_ADD, R_TMP, R_ZERO, R_ZERO};
        endcase
        return u;
    endfunction

endpackage

// ===== hdl/angle_bias_kalman_filter_top.sv =====
// Two-state angle/gyro-bias Kalman filter with bit-serial multiply and divide.
//
//  channel | ports                          | beat contents
//  --------+--------------------------------+----------------------------------------
//  input   | s_tvalid s_tready s_tdata[63:0]| accel_angle, gyro_rate
//  result  | m_tvalid m_tready m_tdata[63:0]| filtered_angle, corrected_rate
//          | m_tuser[0]                     | saturated
//  config  | cfg_valid cfg_ready cfg_index  | register index 0..4, write data
//          | cfg_data[31:0]                 |
//
//  One sample runs a fixed list of 34 micro-ops: the 18 add/sub write their result at
//  once; each of the 14 multiplies issues, takes one multiplier bit a cycle, then writes;
//  each of the 2 divides issues, takes one quotient bit a cycle, then writes (a zero
//  divisor writes a zero gain at once). The serial multiplier and divider set the
//  sample time. Reset (aresetn low, synchronous) restores the registers, zero angle and
//  bias and identity covariance. A result held by m_tready low blocks the end of the
//  next sample only; the next input beat is still taken.
module angle_bias_kalman_filter_top
    import abkf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] accel_angle, [63:32] gyro_rate
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] filtered_angle, [63:32] corrected_rate
    output logic [0:0]  m_tuser,    // [0] saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_DONE} state_t;

    state_t state_reg;
    logic [PC_W-1:0] pc_reg;
    logic [5:0]      cnt_reg;
    logic            sat_reg;

    // configuration
    logic [16:0]   dt_reg;
    logic [30:0]   qa_reg, qg_reg, r_reg;
    logic [DW-1:0] c_reg;

    // filter state and scratch
    logic [DW-1:0] a_reg, b_reg, p0_reg, p1_reg, p2_reg, p3_reg;
    logic [DW-1:0] acc_reg, gyr_reg, err_reg, tmp_reg, pd0_reg, pd1_reg;
    logic [DW-1:0] pct0_reg, pct1_reg, e_reg, k0_reg, k1_reg, t1_reg, rate_reg;

    // serial arithmetic
    logic [63:0]   prod_reg;
    logic [DW-1:0] mcand_reg, mplr_reg;
    logic [QW-1:0] num_reg, quo_reg;
    logic [DW-1:0] rem_reg;
    logic          neg_reg;

    uop_t          uop;
    logic [DW-1:0] opa, opb;
    logic [DW-1:0] mag_a, mag_b;
    sat_val_t      alu_res, mul_res, div_res;
    logic [DW:0]   psum;
    logic [DW:0]   rem_sh;
    logic          rem_ge;
    logic [63:0]   prod_rnd;
    logic          s_accept, m_accept;

    function automatic logic [DW-1:0] pick(input reg_sel_t s,
            input logic [DW-1:0] a, b, p0, p1, p2, p3, acc, gyr, err, tmp,
            input logic [DW-1:0] pd0, pd1, pct0, pct1, e, k0, k1, t1, c,
            input logic [16:0] dt, input logic [30:0] qa, qg, r);
        logic [DW-1:0] v;
        unique case (s)
            R_A:    v = a;
            R_B:    v = b;
            R_P0:   v = p0;
            R_P1:   v = p1;
            R_P2:   v = p2;
            R_P3:   v = p3;
            R_ACC:  v = acc;
            R_GYR:  v = gyr;
            R_ERR:  v = err;
            R_TMP:  v = tmp;
            R_PD0:  v = pd0;
            R_PD1:  v = pd1;
            R_PCT0: v = pct0;
            R_PCT1: v = pct1;
            R_E:    v = e;
            R_K0:   v = k0;
            R_K1:   v = k1;
            R_T1:   v = t1;
            R_DT:   v = DW'(dt);
            R_QA:   v = DW'(qa);
            R_QG:   v = DW'(qg);
            R_R:    v = DW'(r);
            R_C:    v = c;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign uop = prog(pc_reg);

    always_comb begin
        opa = pick(uop.src_a, a_reg, b_reg, p0_reg, p1_reg, p2_reg, p3_reg, acc_reg,
                   gyr_reg, err_reg, tmp_reg, pd0_reg, pd1_reg, pct0_reg, pct1_reg,
                   e_reg, k0_reg, k1_reg, t1_reg, c_reg, dt_reg, qa_reg, qg_reg, r_reg);
        opb = pick(uop.src_b, a_reg, b_reg, p0_reg, p1_reg, p2_reg, p3_reg, acc_reg,
                   gyr_reg, err_reg, tmp_reg, pd0_reg, pd1_reg, pct0_reg, pct1_reg,
                   e_reg, k0_reg, k1_reg, t1_reg, c_reg, dt_reg, qa_reg, qg_reg, r_reg);
    end

    assign mag_a   = opa[DW-1] ? (DW'(0) - opa) : opa;
    assign mag_b   = opb[DW-1] ? (DW'(0) - opb) : opb;
    assign alu_res = add_sat(opa, opb, uop.op == OP_SUB);

    // multiplier: add the multiplicand into the top half, shift right one bit
    assign psum     = {1'b0, prod_reg[63:32]} + (mplr_reg[0] ? {1'b0, mcand_reg} : '0);
    assign prod_rnd = prod_reg + 64'(1 << (FB - 1));
    assign mul_res  = from_mag(neg_reg, prod_rnd[FB +: QW]);

    // restoring divider: one quotient bit a cycle
    assign rem_sh  = {rem_reg, num_reg[QW-1]};
    assign rem_ge  = rem_sh >= {1'b0, e_reg[DW-1] ? (DW'(0) - e_reg) : e_reg};
    assign div_res = from_mag(neg_reg, quo_reg);

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
            m_tvalid  <= 1'b0;
            dt_reg    <= RST_STEP_TIME;
            qa_reg    <= RST_ANGLE_NOISE;
            qg_reg    <= RST_BIAS_NOISE;
            r_reg     <= RST_MEASURE_NOISE;
            c_reg     <= ONE_FX;
            a_reg     <= '0;
            b_reg     <= '0;
            p0_reg    <= ONE_FX;
            p1_reg    <= '0;
            p2_reg    <= '0;
            p3_reg    <= ONE_FX;
        end else begin
            // drop the beat once taken; the output stage reloads it itself
            if (m_accept && state_reg != ST_DONE) begin
                m_tvalid <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_STEP_TIME:     dt_reg <= cfg_data[16:0];
                    CFG_ANGLE_NOISE:   qa_reg <= cfg_data[30:0];
                    CFG_BIAS_NOISE:    qg_reg <= cfg_data[30:0];
                    CFG_MEASURE_NOISE: r_reg  <= cfg_data[30:0];
                    CFG_OBSERVE_GAIN:  c_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // result of this cycle's micro-op, if one completes
            begin : exec
                logic          wr;
                logic [DW-1:0] wv;
                wr = 1'b0;
                wv = '0;
                unique case (state_reg)
                    ST_IDLE: begin
                        if (s_accept) begin
                            acc_reg   <= s_tdata[31:0];
                            gyr_reg   <= s_tdata[63:32];
                            sat_reg   <= 1'b0;
                            pc_reg    <= '0;
                            state_reg <= ST_EXEC;
                        end
                    end
                    ST_EXEC: begin
                        unique case (uop.op)
                            OP_ADD, OP_SUB: begin
                                wr = 1'b1;
                                wv = alu_res.val;
                                if (alu_res.sat) sat_reg <= 1'b1;
                            end
                            OP_MUL: begin
                                prod_reg  <= '0;
                                mcand_reg <= mag_a;
                                mplr_reg  <= mag_b;
                                neg_reg   <= opa[DW-1] != opb[DW-1];
                                cnt_reg   <= '0;
                                state_reg <= ST_MUL;
                            end
                            default: begin
                                if (opb == '0) begin
                                    // zero innovation variance: force the gain to zero
                                    wr = 1'b1;
                                    wv = '0;
                                    sat_reg <= 1'b1;
                                end else begin
                                    num_reg   <= {mag_a, {FB{1'b0}}};
                                    quo_reg   <= '0;
                                    rem_reg   <= '0;
                                    neg_reg   <= opa[DW-1] != opb[DW-1];
                                    cnt_reg   <= '0;
                                    state_reg <= ST_DIV;
                                end
                            end
                        endcase
                    end
                    ST_MUL: begin
                        if (cnt_reg == 6'(DW)) begin
                            wr = 1'b1;
                            wv = mul_res.val;
                            if (mul_res.sat) sat_reg <= 1'b1;
                        end else begin
                            prod_reg <= {psum, prod_reg[31:1]};
                            mplr_reg <= mplr_reg >> 1;
                            cnt_reg  <= cnt_reg + 6'd1;
                        end
                    end
                    ST_DIV: begin
                        if (cnt_reg == 6'(QW)) begin
                            wr = 1'b1;
                            wv = div_res.val;
                            if (div_res.sat) sat_reg <= 1'b1;
                        end else begin
                            rem_reg <= rem_ge ? DW'(rem_sh - {1'b0, e_reg[DW-1] ?
                                                (DW'(0) - e_reg) : e_reg}) : rem_sh[DW-1:0];
                            quo_reg <= {quo_reg[QW-2:0], rem_ge};
                            num_reg <= num_reg << 1;
                            cnt_reg <= cnt_reg + 6'd1;
                        end
                    end
                    ST_DONE: begin
                        // hold until the output register is free
                        if (!m_tvalid || m_tready) begin
                            m_tvalid          <= 1'b1;
                            m_tdata           <= {rate_reg, a_reg};
                            m_tuser           <= sat_reg;
                            state_reg         <= ST_IDLE;
                        end
                    end
                    default: state_reg <= ST_IDLE;
                endcase

                if (wr) begin
                    case (uop.dst)
                        R_A:    a_reg    <= wv;
                        R_B:    b_reg    <= wv;
                        R_P0:   p0_reg   <= wv;
                        R_P1:   p1_reg   <= wv;
                        R_P2:   p2_reg   <= wv;
                        R_P3:   p3_reg   <= wv;
                        R_ERR:  err_reg  <= wv;
                        R_TMP:  tmp_reg  <= wv;
                        R_PD0:  pd0_reg  <= wv;
                        R_PD1:  pd1_reg  <= wv;
                        R_PCT0: pct0_reg <= wv;
                        R_PCT1: pct1_reg <= wv;
                        R_E:    e_reg    <= wv;
                        R_K0:   k0_reg   <= wv;
                        R_K1:   k1_reg   <= wv;
                        R_T1:   t1_reg   <= wv;
                        R_RATE: rate_reg <= wv;
                        default: ;
                    endcase
                    // advance; the last micro-op leads to the output stage
                    if (pc_reg == PC_W'(PROG_LEN - 1)) begin
                        state_reg <= ST_DONE;
                    end else begin
                        pc_reg    <= pc_reg + PC_W'(1);
                        state_reg <= ST_EXEC;
                    end
                end
            end
        end
    end

    // an accepted beat always starts the micro-program at its first op
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_EXEC && pc_reg == '0))
        else $error("sample did not start at the first micro-op");

    // the program counter never runs past the program
    a_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg < PC_W'(PROG_LEN))
        else $error("program counter out of range");

    // a new result is loaded only when the output register is free or drained
    a_noloss: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid && !m_tready) |=> state_reg == ST_DONE)
        else $error("result overwritten while held");

endmodule

// ===== tb/sv/abkf_checker.sv =====
// Checker for the angle/bias Kalman filter: tracks config, predicts each sample, compares results.
module abkf_checker
    import abkf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          sat_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        sat;
        logic [31:0] rate;
        logic [31:0] angle;
    } sample_out_t;

    localparam longint FMAX = 64'sd2147483647;
    localparam longint FMIN = -64'sd2147483648;

    longint dt_q, qa_q, qg_q, r_q, c_q;
    longint ang_q, bias_q;
    longint cov [4];
    bit     sat_q;
    sample_out_t outq [$];

    function automatic longint clampw(longint v);
        if (v > FMAX) begin
            sat_q = 1;
            return FMAX;
        end
        if (v < FMIN) begin
            sat_q = 1;
            return FMIN;
        end
        return v;
    endfunction

    // Values stay within 32 bits, so 64-bit sums are exact before clamping.
    function automatic longint sadd(longint a, longint b);
        return clampw(a + b);
    endfunction

    function automatic longint ssub(longint a, longint b);
        return clampw(a - b);
    endfunction

    // Exact product, round half away from zero on the magnitude.
    function automatic longint smul(longint a, longint b);
        logic [63:0] x, y, p;
        logic [63:0] m;
        bit          neg;
        x = a < 0 ? -a : a;
        y = b < 0 ? -b : b;
        p = x * y;
        m = (p + 64'd32768) >> FB;
        neg = (a < 0) != (b < 0);
        return neg ? clampw(-$signed(m)) : clampw($signed(m));
    endfunction

    // (a << 16) / d truncated toward zero.
    function automatic longint sdiv(longint a, longint d);
        logic [63:0] x, y, q;
        bit          neg;
        x = a < 0 ? -a : a;
        y = d < 0 ? -d : d;
        q = (x << FB) / y;
        neg = (a < 0) != (d < 0);
        if (q[63]) begin
            sat_q = 1;
            return neg ? FMIN : FMAX;
        end
        return neg ? clampw(-$signed(q)) : clampw($signed(q));
    endfunction

    function automatic sample_out_t filter_sample(logic [31:0] acc_in, logic [31:0] gyr_in);
        longint acc, gyr, err, pd0, pd1, pct0, pct1, e, k0, k1, t1;
        sample_out_t o;
        sat_q = 0;
        acc = longint'($signed(acc_in));
        gyr = longint'($signed(gyr_in));
        k0 = 0;
        k1 = 0;
        ang_q = sadd(ang_q, smul(ssub(gyr, bias_q), dt_q));
        err = ssub(acc, ang_q);
        pd0 = ssub(ssub(qa_q, cov[1]), cov[2]);
        pd1 = ssub(0, cov[3]);
        cov[0] = sadd(cov[0], smul(pd0, dt_q));
        cov[1] = sadd(cov[1], smul(pd1, dt_q));
        cov[2] = sadd(cov[2], smul(pd1, dt_q));
        cov[3] = sadd(cov[3], smul(qg_q, dt_q));
        pct0 = smul(c_q, cov[0]);
        pct1 = smul(c_q, cov[2]);
        e = sadd(r_q, smul(c_q, pct0));
        if (e == 0) begin
            sat_q = 1;
        end else begin
            k0 = sdiv(pct0, e);
            k1 = sdiv(pct1, e);
        end
        t1 = smul(c_q, cov[1]);
        cov[0] = ssub(cov[0], smul(k0, pct0));
        cov[1] = ssub(cov[1], smul(k0, t1));
        cov[2] = ssub(cov[2], smul(k1, pct0));
        cov[3] = ssub(cov[3], smul(k1, t1));
        ang_q = sadd(ang_q, smul(k0, err));
        bias_q = sadd(bias_q, smul(k1, err));
        o.angle = ang_q[31:0];
        o.rate = 32'(ssub(gyr, bias_q));
        o.sat = sat_q;
        return o;
    endfunction

    always @(posedge aclk) begin
        sample_out_t want;
        sample_out_t got;
        if (!aresetn) begin
            dt_q <= 655;
            qa_q <= 6554;
            qg_q <= 6554;
            r_q <= 32768;
            c_q <= 65536;
            ang_q = 0;
            bias_q = 0;
            cov = '{65536, 0, 0, 65536};
            outq.delete();
            fail_count <= 0;
            results_seen <= 0;
            sat_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STEP_TIME:     dt_q <= cfg_data[16:0];
                    CFG_ANGLE_NOISE:   qa_q <= cfg_data[30:0];
                    CFG_BIAS_NOISE:    qg_q <= cfg_data[30:0];
                    CFG_MEASURE_NOISE: r_q <= cfg_data[30:0];
                    CFG_OBSERVE_GAIN:  c_q <= longint'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                outq.push_back(filter_sample(s_tdata[31:0], s_tdata[63:32]));
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tdata[63:32], m_tdata[31:0]};
                results_seen <= results_seen + 1;
                if (got.sat)
                    sat_seen <= sat_seen + 1;
                if (outq.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result beat with nothing expected: %h", $realtime, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = outq.pop_front();
                    if (want != got) begin
                        if (fail_count < 10)
                            $display("%0t: mismatch angle %h/%h rate %h/%h sat %b/%b (exp/act)",
                                     $realtime, want.angle, got.angle, want.rate, got.rate,
                                     want.sat, got.sat);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    assign pending = outq.size();
endmodule

// ===== tb/sv/angle_bias_kalman_filter_top_tb.sv =====
// Top of the angle/bias Kalman filter testbench: clock, reset, stimulus, verdict.
module angle_bias_kalman_filter_top_tb;
    import abkf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Whole-run cycle limit, with room for stalls on every beat.
    localparam longint CYCLE_LIMIT = 64'd12_000_000;
    localparam int     DRAIN_CYCLES = 800;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    int     fail_count, pending, results_seen, sat_seen;
    int     send_idle_pct, recv_stall_pct;
    longint cycle_count;

    angle_bias_kalman_filter_top uut (.*);

    abkf_checker chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: count cycles and bail out if the run hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("angle_bias_kalman_filter_top_tb: errors");
            $finish;
        end
    end

    // Stall the result channel at the current phase's rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one sample beat, idling first at the current phase's rate.
    task automatic send_sample(input logic [31:0] acc, input logic [31:0] gyr);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {gyr, acc};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Write one register; only called with nothing in flight.
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold until every expected result has drained.
    task automatic drain;
        while (pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_phase(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Random sample: mostly realistic small angles and rates, sometimes full range.
    task automatic random_sample;
        logic [31:0] acc, gyr;
        if ($urandom_range(9) < 7) begin
            acc = 32'($signed($urandom_range(20 << 16)) - (10 << 16));
            gyr = 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        end else begin
            acc = $urandom;
            gyr = $urandom;
        end
        send_sample(acc, gyr);
    endtask

    // Write all registers with a fresh setting.
    task automatic load_setting(input logic [31:0] dt, input logic [31:0] qa,
                                input logic [31:0] qg, input logic [31:0] r,
                                input logic [31:0] c);
        drain();
        write_reg(CFG_STEP_TIME, dt);
        write_reg(CFG_ANGLE_NOISE, qa);
        write_reg(CFG_BIAS_NOISE, qg);
        write_reg(CFG_MEASURE_NOISE, r);
        write_reg(CFG_OBSERVE_GAIN, c);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STEP_TIME;
        cfg_data = '0;
        cycle_count = 0;
        set_phase(0, 0);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes at reset settings.
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h8000_0000);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001);
        send_sample(32'h0001_0000, 32'hFFFF_0000);
        send_sample(32'h5555_5555, 32'hAAAA_AAAA);

        // Zero innovation variance: no measurement noise and zero gain.
        load_setting(32'd655, 32'd6554, 32'd6554, 32'd0, 32'd0);
        send_sample(32'h0002_0000, 32'h0001_0000);
        send_sample(32'hFFFE_0000, 32'h0000_8000);
        // Step time zero: prediction must leave everything alone.
        load_setting(32'd0, 32'd0, 32'd0, 32'd32768, 32'h0001_0000);
        send_sample(32'h0003_0000, 32'h0100_0000);
        send_sample(32'h0000_4000, 32'h8000_0000);
        // Largest step, noises and a negative extreme gain: drive saturation.
        load_setting(32'h0001_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'h8000_0000);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h1234_5678, 32'h8765_4321);
        load_setting(32'h0001_0000, 32'd1, 32'd1, 32'd1, 32'h7FFF_FFFF);
        send_sample(32'h0000_0001, 32'hFFFF_FFFF);
        send_sample(32'h7FFF_0000, 32'h0000_0000);
        // Unknown register indexes must be ignored.
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= 3'd5;
        cfg_data <= 32'hFFFF_FFFF;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_index <= 3'd7;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        send_sample(32'h0001_0000, 32'h0000_1000);

        // Random: four idle/stall phases, each under three settings.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_phase(0, 0);
                1: set_phase(45, 0);
                2: set_phase(0, 45);
                default: set_phase(13, 13);
            endcase
            for (int s = 0; s < 3; s++) begin
                if (s == 0)
                    load_setting(32'd655, 32'd6554, 32'd6554, 32'd32768, 32'h0001_0000);
                else
                    load_setting($urandom_range(32'h1_FFFF), $urandom_range(1 << 18),
                                 $urandom_range(1 << 18), $urandom_range(1 << 20),
                                 $urandom_range(9) < 8 ?
                                     32'($signed($urandom_range(4 << 16)) - (2 << 16)) :
                                     $urandom);
                for (int i = 0; i < 125; i++)
                    random_sample();
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d results (%0d saturated) over four idle/stall phases",
                 results_seen, sat_seen);
        if (fail_count == 0 && pending == 0)
            $display("angle_bias_kalman_filter_top_tb: clean");
        else
            $display("angle_bias_kalman_filter_top_tb: errors");
        $finish;
    end
endmodule
